@@ rtl/cbrs_pkg.sv @@
package cbrs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_DETECTED   = 3'd1,
    PH_WAITING    = 3'd2,
    PH_RECOVERING = 3'd3,
    PH_RECOVERED  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    TM_ELAPSED = 2'd0,
    TM_STOPPED = 2'd1,
    TM_RUNNING = 2'd2
  } tmr_status_t;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] REP_NONE   = 2'd0;
  localparam logic [1:0] REP_FAILED = 2'd1;
  localparam logic [1:0] REP_PASSED = 2'd2;

  localparam logic [1:0] SETTLE_TICKS = 2'd2;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_QUICK_LIMIT = 2'd0;
  localparam logic [1:0] REG_SHORT_DELAY = 2'd1;
  localparam logic [1:0] REG_LONG_DELAY  = 2'd2;
  localparam logic [1:0] REG_FAULT_THRES = 2'd3;

  localparam logic [7:0]  QUICK_LIMIT_RST = 8'd9;
  localparam logic [15:0] SHORT_DELAY_RST = 16'd20;
  localparam logic [15:0] LONG_DELAY_RST  = 16'd200;
  localparam logic [7:0]  FAULT_THRES_RST = 8'd9;

  typedef struct packed {
    logic [7:0]  quick_retry_limit;
    logic [15:0] short_delay_ticks;
    logic [15:0] long_delay_ticks;
    logic [7:0]  fault_report_threshold;
  } cfg_t;

  typedef struct packed {
    logic busoff_event;
    logic busoff_still_present;
    logic processing_enabled;
    logic ign_low_fault;
    logic ign_high_fault;
  } in_item_t;

  typedef struct packed {
    logic [1:0] controller_command;
    logic [1:0] fault_report;
    phase_t     recovery_phase;
    logic [7:0] retry_count_out;
    logic       busoff_flag;
  } res_t;

endpackage

@@ rtl/cbrs_if.sv @@
interface cbrs_in_if;
  logic valid;
  logic ready;
  logic busoff_event;
  logic busoff_still_present;
  logic processing_enabled;
  logic ign_low_fault;
  logic ign_high_fault;

  modport source (
    output valid, busoff_event, busoff_still_present, processing_enabled,
           ign_low_fault, ign_high_fault,
    input  ready
  );
  modport sink (
    input  valid, busoff_event, busoff_still_present, processing_enabled,
           ign_low_fault, ign_high_fault,
    output ready
  );
endinterface

interface cbrs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] controller_command;
  logic [1:0] fault_report;
  logic [2:0] recovery_phase;
  logic [7:0] retry_count_out;
  logic       busoff_flag;

  modport source (
    output valid, controller_command, fault_report, recovery_phase,
           retry_count_out, busoff_flag,
    input  ready
  );
  modport sink (
    input  valid, controller_command, fault_report, recovery_phase,
           retry_count_out, busoff_flag,
    output ready
  );
endinterface

@@ rtl/cbrs_apb_regs.sv @@
module cbrs_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbrs_pkg::CFG_AW-1:0] paddr,
  input  logic [cbrs_pkg::CFG_DW-1:0] pwdata,
  output logic [cbrs_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output cbrs_pkg::cfg_t              cfg
);
  import cbrs_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quick_retry_limit      <= QUICK_LIMIT_RST;
      cfg_r.short_delay_ticks      <= SHORT_DELAY_RST;
      cfg_r.long_delay_ticks       <= LONG_DELAY_RST;
      cfg_r.fault_report_threshold <= FAULT_THRES_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_QUICK_LIMIT: cfg_r.quick_retry_limit      <= pwdata[7:0];
        REG_SHORT_DELAY: cfg_r.short_delay_ticks      <= pwdata[15:0];
        REG_LONG_DELAY:  cfg_r.long_delay_ticks       <= pwdata[15:0];
        REG_FAULT_THRES: cfg_r.fault_report_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUICK_LIMIT: prdata = {24'd0, cfg_r.quick_retry_limit};
      REG_SHORT_DELAY: prdata = {16'd0, cfg_r.short_delay_ticks};
      REG_LONG_DELAY:  prdata = {16'd0, cfg_r.long_delay_ticks};
      REG_FAULT_THRES: prdata = {24'd0, cfg_r.fault_report_threshold};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/cbrs_seq.sv @@
module cbrs_seq #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbrs_pkg::in_item_t in_item,
  input  cbrs_pkg::cfg_t     cfg,
  output logic               res_valid,
  input  logic               res_ready,
  output cbrs_pkg::res_t     res
);
  import cbrs_pkg::*;

  // input register
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     adv;

  // sequencer state
  phase_t                 phase_r,   phase_nxt;
  logic [7:0]             retry_r,   retry_nxt;
  tmr_status_t            tst_r,     tst_nxt;
  logic [TIMER_WIDTH-1:0] tcnt_r,    tcnt_nxt;
  logic [1:0]             settle_r,  settle_nxt;
  logic                   flag_r,    flag_nxt;

  logic [31:0]            short_ext, long_ext;
  logic [TIMER_WIDTH-1:0] short_arm, long_arm;
  logic [1:0]             cmd, rep;

  assign adv       = s1_valid_r & res_ready;
  assign in_ready  = ~s1_valid_r | res_ready;
  assign res_valid = s1_valid_r;

  // delays are cut or zero-extended to the timer width
  assign short_ext = 32'(cfg.short_delay_ticks);
  assign long_ext  = 32'(cfg.long_delay_ticks);
  assign short_arm = short_ext[TIMER_WIDTH-1:0];
  assign long_arm  = long_ext[TIMER_WIDTH-1:0];

  always_comb begin
    phase_nxt  = phase_r;
    retry_nxt  = retry_r;
    tst_nxt    = tst_r;
    tcnt_nxt   = tcnt_r;
    settle_nxt = settle_r;
    flag_nxt   = flag_r;
    cmd        = CMD_NONE;
    rep        = REP_NONE;

    // timer runs regardless of enable
    if (tst_r == TM_RUNNING) begin
      if (tcnt_r != '0) begin
        tcnt_nxt = tcnt_r - 1'b1;
        if (tcnt_r == TIMER_WIDTH'(1)) tst_nxt = TM_ELAPSED;
      end else begin
        tst_nxt = TM_ELAPSED;
      end
    end

    if (s1_item_r.busoff_event) begin
      flag_nxt  = 1'b1;
      phase_nxt = PH_DETECTED;
    end

    if (s1_item_r.processing_enabled) begin
      case (phase_nxt)
        PH_DETECTED: begin
          settle_nxt = 2'd0;
          tst_nxt    = TM_RUNNING;
          if (retry_r < cfg.quick_retry_limit) begin
            retry_nxt = retry_r + 8'd1;
            tcnt_nxt  = short_arm;
          end else begin
            tcnt_nxt  = long_arm;
          end
          if (retry_nxt >= cfg.fault_report_threshold) rep = REP_FAILED;
          phase_nxt = PH_WAITING;
          cmd       = CMD_STOP;
        end
        PH_WAITING: begin
          if (tst_nxt == TM_ELAPSED) begin
            cmd       = CMD_START;
            phase_nxt = PH_RECOVERING;
          end
        end
        PH_RECOVERING: begin
          if (settle_r == SETTLE_TICKS) phase_nxt  = PH_RECOVERED;
          else                          settle_nxt = settle_r + 2'd1;
        end
        PH_RECOVERED: begin
          settle_nxt = 2'd0;
          flag_nxt   = 1'b0;
          if (!s1_item_r.busoff_still_present) begin
            retry_nxt = 8'd0;
            if (!s1_item_r.ign_low_fault && !s1_item_r.ign_high_fault) begin
              rep       = REP_PASSED;
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.controller_command = cmd;
    res.fault_report       = rep;
    res.recovery_phase     = phase_nxt;
    res.retry_count_out    = retry_nxt;
    res.busoff_flag        = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      retry_r  <= 8'd0;
      tst_r    <= TM_STOPPED;
      tcnt_r   <= '0;
      settle_r <= 2'd0;
      flag_r   <= 1'b0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      retry_r  <= retry_nxt;
      tst_r    <= tst_nxt;
      tcnt_r   <= tcnt_nxt;
      settle_r <= settle_nxt;
      flag_r   <= flag_nxt;
    end
  end

endmodule

@@ rtl/cbrs_out_stage.sv @@
module cbrs_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  output logic           res_ready,
  input  cbrs_pkg::res_t res,
  output logic           out_valid,
  input  logic           out_ready,
  output cbrs_pkg::res_t out_res
);
  import cbrs_pkg::*;

  logic valid_r;
  res_t res_r;

  assign res_ready = ~valid_r | out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) res_r <= res;
  end

endmodule

@@ rtl/can_busoff_recovery_sequencer_unit.sv @@
// Path: an accepted item is registered in the input register and then in the result register
//   before its result is valid on the output channel.
// Throughput: one item per cycle while out_ready stays high; the state update is a single pass.
// A stalled result holds in the result register; the input register takes one more item,
//   then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous): phase idle, counts and flags cleared, timer stopped,
//   configuration back to limit 9, delays 20 and 200 ticks, threshold 9.
module can_busoff_recovery_sequencer_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cbrs_in_if.sink                     in_ch,
  cbrs_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cbrs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cbrs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cbrs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import cbrs_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  res_t     res, out_res;
  logic     res_valid, res_ready;

  assign in_item.busoff_event         = in_ch.busoff_event;
  assign in_item.busoff_still_present = in_ch.busoff_still_present;
  assign in_item.processing_enabled   = in_ch.processing_enabled;
  assign in_item.ign_low_fault        = in_ch.ign_low_fault;
  assign in_item.ign_high_fault       = in_ch.ign_high_fault;

  cbrs_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cbrs_seq #(.TIMER_WIDTH(TIMER_WIDTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  cbrs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.controller_command = out_res.controller_command;
  assign out_ch.fault_report       = out_res.fault_report;
  assign out_ch.recovery_phase     = out_res.recovery_phase;
  assign out_ch.retry_count_out    = out_res.retry_count_out;
  assign out_ch.busoff_flag        = out_res.busoff_flag;

endmodule

@@ rtl/cbrs_checker.sv @@
module cbrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_command,
  input logic [1:0] out_report,
  input logic [2:0] out_phase,
  input logic [7:0] out_retry,
  input logic       out_flag
);
  import cbrs_pkg::*;

  // nothing left over from before reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase) && $stable(out_retry))
    else $error("stalled item changed");

  a_stop_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_STOP |-> out_phase == PH_WAITING && out_flag)
    else $error("stop command outside waiting phase");

  a_start_recovers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_START |-> out_phase == PH_RECOVERING)
    else $error("start command outside recovering phase");

  a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report == REP_PASSED
      |-> out_phase == PH_IDLE && out_retry == 8'd0 && !out_flag)
    else $error("passed report with live bus-off state");

endmodule

bind can_busoff_recovery_sequencer_unit cbrs_checker u_cbrs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_command (out_ch.controller_command),
  .out_report  (out_ch.fault_report),
  .out_phase   (out_ch.recovery_phase),
  .out_retry   (out_ch.retry_count_out),
  .out_flag    (out_ch.busoff_flag)
);
